// File: hdl/dmx_pkg.sv
// shared types, constants and codes of the dmx512 frame receiver
package dmx_pkg;

    localparam int MAX_BYTES_DEF  = 513;
    localparam int CH_W           = 10;
    localparam int CNT_W          = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CNT_W-1:0] BREAK_MIN_RST   = 16'd88;
    localparam logic [CNT_W-1:0] BYTE_TMO_RST    = 16'd25000;
    localparam logic [CNT_W-1:0] CNT_SAT         = 16'hFFFF;
    localparam logic [7:0]       START_CODE      = 8'h00;

    // register indexes on the configuration port
    localparam logic REG_BREAK_MIN = 1'b0;
    localparam logic REG_BYTE_TMO  = 1'b1;

    // item function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic            func;
        logic            line_level;
        logic            byte_valid;
        logic [7:0]      byte_value;
        logic [CH_W-1:0] channel_index;
    } item_t;

    typedef struct packed {
        logic            frame_done;
        logic            frame_error;
        logic [CH_W-1:0] channel_count;
        logic            read_valid;
        logic [7:0]      read_data;
    } result_t;

    // classified work for the back end
    typedef struct packed {
        logic            is_read;
        logic            rd_ok;
        logic            wr_en;
        logic [CH_W-1:0] addr;
        logic [7:0]      wr_data;
        logic            done;
        logic            err;
        logic [CH_W-1:0] count;
    } cmd_t;

endpackage

// File: hdl/dmx512_frame_receiver.sv
// top level of the dmx512 frame receiver: register port, front end, queue, back end
// path: an item's command passes the queue, the back end's store stage and the result register
// throughput: one item per cycle unless stalled; front, queue and back end each move one command a cycle
// each item costs at most one store access (a byte write or a slot read) and nothing more
// reset: line hunt restarts, counters clear, registers load 88 and 25000 ticks
// the frame store is not cleared; a slot reads as undefined until written
module dmx512_frame_receiver #(
    parameter int MAX_BYTES = dmx_pkg::MAX_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              item_valid,
    output logic                              item_stall,
    input  dmx_pkg::item_t                    item_data,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output dmx_pkg::result_t                  result_data,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dmx_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [dmx_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [dmx_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import dmx_pkg::*;

    logic [CNT_W-1:0] break_min_reg;
    logic [CNT_W-1:0] byte_tmo_reg;
    logic             cfg_wr;
    logic             reg_sel;

    logic             push;
    cmd_t             push_cmd;
    logic             queue_full;
    logic             pop;
    logic             not_empty;
    cmd_t             head;

    // register port: always ready, word address selects the register
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_min_reg <= BREAK_MIN_RST;
            byte_tmo_reg  <= BYTE_TMO_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_BREAK_MIN: break_min_reg <= pwdata[CNT_W-1:0];
                REG_BYTE_TMO:  byte_tmo_reg  <= pwdata[CNT_W-1:0];
                default:       break_min_reg <= break_min_reg;
            endcase
        end
    end

    // read back the selected register
    always_comb
    begin
        unique case (reg_sel)
            REG_BREAK_MIN: prdata = CFG_DATA_W'(break_min_reg);
            REG_BYTE_TMO:  prdata = CFG_DATA_W'(byte_tmo_reg);
            default:       prdata = '0;
        endcase
    end

    // front end tracks break, mark-after-break and capture timing, and turns
    // each item beat into a command, carrying a store write, a frame report, a read or none of them
    dmx_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .break_min  (break_min_reg),
        .byte_tmo   (byte_tmo_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // commands keep their order, so a read sees every earlier byte write
    dmx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    // back end owns the frame store and the result register, so a stalled
    // result only holds the queue, never the line timing directly
    dmx_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// File: hdl/dmx_ram.sv
// generic single-clock ram, one write and one registered read port
module dmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 513
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/dmx_front.sv
// front end: break hunt, capture timing and item classification
module dmx_front #(
    parameter int MAX_BYTES = dmx_pkg::MAX_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  dmx_pkg::item_t                item_data,
    input  logic [dmx_pkg::CNT_W-1:0]     break_min,
    input  logic [dmx_pkg::CNT_W-1:0]     byte_tmo,
    input  logic                          queue_full,
    output logic                          push,
    output dmx_pkg::cmd_t                 push_cmd
);
    import dmx_pkg::*;

    localparam int BW = $clog2(MAX_BYTES + 1);

    typedef enum logic [1:0] {
        WAIT_LOW,
        COUNT_LOW,
        WAIT_HIGH,
        CAPTURE
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  tick_reg, tick_next;
    logic [BW-1:0]     bcount_reg, bcount_next;
    logic [7:0]        start_reg, start_next;

    logic              accept;
    logic              is_tick;
    logic [CNT_W-1:0]  bmin;
    logic [CNT_W-1:0]  tmo;
    logic [CNT_W-1:0]  tick_inc;
    logic [BW-1:0]     bcount_inc;
    logic              finish;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;
    assign push       = accept;
    assign is_tick    = (item_data.func == FUNC_TICK);

    // zero acts like one
    assign bmin       = (break_min == '0) ? CNT_W'(1) : break_min;
    assign tmo        = (byte_tmo == '0) ? CNT_W'(1) : byte_tmo;
    assign tick_inc   = (tick_reg == CNT_SAT) ? tick_reg : tick_reg + CNT_W'(1);
    assign bcount_inc = bcount_reg + BW'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bcount_next = bcount_reg;
        start_next  = start_reg;
        finish      = 1'b0;

        push_cmd         = '0;
        push_cmd.is_read = !is_tick;
        push_cmd.rd_ok   = ({1'b0, item_data.channel_index} < (CH_W + 1)'(MAX_BYTES));
        push_cmd.addr    = item_data.channel_index;
        push_cmd.wr_data = item_data.byte_value;

        if (is_tick)
        begin
            push_cmd.rd_ok = 1'b0;
            unique case (phase_reg)
                WAIT_LOW:
                begin
                    if (!item_data.line_level)
                    begin
                        tick_next  = CNT_W'(1);
                        phase_next = (bmin == CNT_W'(1)) ? WAIT_HIGH : COUNT_LOW;
                    end
                end
                COUNT_LOW:
                begin
                    if (item_data.line_level)
                    begin
                        phase_next = WAIT_LOW;
                        tick_next  = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= bmin)
                        begin
                            phase_next = WAIT_HIGH;
                        end
                    end
                end
                WAIT_HIGH:
                begin
                    if (item_data.line_level)
                    begin
                        phase_next  = CAPTURE;
                        tick_next   = '0;
                        bcount_next = '0;
                    end
                end
                CAPTURE:
                begin
                    if (item_data.byte_valid)
                    begin
                        push_cmd.wr_en = 1'b1;
                        push_cmd.addr  = CH_W'(bcount_reg);
                        if (bcount_reg == '0)
                        begin
                            start_next = item_data.byte_value;
                        end
                        bcount_next = bcount_inc;
                        tick_next   = '0;
                        finish      = (bcount_inc >= BW'(MAX_BYTES));
                    end
                    else
                    begin
                        tick_next = tick_inc;
                        finish    = (tick_inc >= tmo);
                    end
                end
                default:
                begin
                    phase_next = WAIT_LOW;
                end
            endcase

            if (finish)
            begin
                phase_next     = WAIT_LOW;
                tick_next      = '0;
                push_cmd.done  = 1'b1;
                push_cmd.err   = (bcount_next == '0) || (start_next != START_CODE);
                push_cmd.count = (bcount_next == '0) ? '0
                                 : CH_W'(bcount_next - BW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= WAIT_LOW;
            tick_reg   <= '0;
            bcount_reg <= '0;
            start_reg  <= '0;
        end
        else if (accept && is_tick)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bcount_reg <= bcount_next;
            start_reg  <= start_next;
        end
    end

endmodule

// File: hdl/dmx_queue.sv
// short command queue between front and back end
module dmx_queue #(
    parameter int DEPTH = dmx_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dmx_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output dmx_pkg::cmd_t head
);
    import dmx_pkg::*;

    localparam int PW = $clog2(DEPTH);

    cmd_t            slot [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     fill_reg, fill_next;
    logic            do_push, do_pop;

    assign full      = (fill_reg == (PW + 1)'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (PW + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/dmx_back.sv
// back end: frame store access and result register
module dmx_back #(
    parameter int MAX_BYTES = dmx_pkg::MAX_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              not_empty,
    input  dmx_pkg::cmd_t     head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output dmx_pkg::result_t  result_data
);
    import dmx_pkg::*;

    localparam int AW = $clog2(MAX_BYTES);

    cmd_t       s1_cmd_reg;
    logic       s1_valid_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    result_t    out_data_next;
    logic       out_free;
    logic       s1_move;
    logic [7:0] rdata;

    assign out_free = !out_valid_reg || !result_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign pop      = not_empty && (!s1_valid_reg || out_free);

    dmx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (pop && head.wr_en),
        .waddr (head.addr[AW-1:0]),
        .wdata (head.wr_data),
        .re    (pop && head.is_read && head.rd_ok),
        .raddr (head.addr[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        out_data_next               = '0;
        out_data_next.frame_done    = s1_cmd_reg.done;
        out_data_next.frame_error   = s1_cmd_reg.err;
        out_data_next.channel_count = s1_cmd_reg.count;
        if (s1_cmd_reg.is_read && s1_cmd_reg.rd_ok)
        begin
            out_data_next.read_valid = 1'b1;
            out_data_next.read_data  = rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg <= head;
        end
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

// File: dv/dmx512_frame_checker.sv
// checker for the dmx512 frame receiver: watches both channels and the register port
module dmx512_frame_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_stall,
    input  dmx_pkg::item_t                 item_data,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  dmx_pkg::result_t               result_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dmx_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dmx_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int                             mismatches,
    output int                             waiting_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import dmx_pkg::*;

    typedef enum logic [1:0] {HUNT_LOW, COUNT_LOW, AWAIT_HIGH, CAPTURE} line_phase_t;

    line_phase_t phase_q;
    logic [CNT_W-1:0] ticks_q;
    int unsigned      bytes_q;
    logic [7:0]       slot_mem [0:MAX_BYTES_DEF-1];
    logic [CNT_W-1:0] break_min_q;
    logic [CNT_W-1:0] timeout_q;
    result_t          pending_answers [$];

    // advances the receiver by one item beat and returns the answer it must give
    function automatic result_t predict_answer(input item_t it);
        result_t          r;
        logic [CNT_W-1:0] bmin;
        logic [CNT_W-1:0] tmo;
        logic             frame_end;
        r = '0;
        frame_end = 1'b0;
        bmin = (break_min_q == '0) ? CNT_W'(1) : break_min_q;
        tmo  = (timeout_q == '0) ? CNT_W'(1) : timeout_q;
        if (it.func == FUNC_READ)
        begin
            if (it.channel_index < MAX_BYTES_DEF)
            begin
                r.read_valid = 1'b1;
                r.read_data  = slot_mem[it.channel_index];
            end
            return r;
        end
        case (phase_q)
            HUNT_LOW:
                if (!it.line_level)
                begin
                    ticks_q = CNT_W'(1);
                    phase_q = (ticks_q >= bmin) ? AWAIT_HIGH : COUNT_LOW;
                end
            COUNT_LOW:
                if (it.line_level)
                begin
                    phase_q = HUNT_LOW;
                    ticks_q = '0;
                end
                else
                begin
                    if (ticks_q != CNT_SAT)
                        ticks_q++;
                    if (ticks_q >= bmin)
                        phase_q = AWAIT_HIGH;
                end
            AWAIT_HIGH:
                if (it.line_level)
                begin
                    phase_q = CAPTURE;
                    ticks_q = '0;
                    bytes_q = 0;
                end
            default:
                if (it.byte_valid)
                begin
                    if (bytes_q < MAX_BYTES_DEF)
                        slot_mem[bytes_q] = it.byte_value;
                    bytes_q++;
                    ticks_q = '0;
                    frame_end = (bytes_q >= MAX_BYTES_DEF);
                end
                else
                begin
                    if (ticks_q != CNT_SAT)
                        ticks_q++;
                    frame_end = (ticks_q >= tmo);
                end
        endcase
        if (frame_end)
        begin
            r.frame_done = 1'b1;
            if (bytes_q == 0)
                r.frame_error = 1'b1;
            else
            begin
                r.frame_error   = (slot_mem[0] != START_CODE);
                r.channel_count = CH_W'(bytes_q - 1);
            end
            phase_q = HUNT_LOW;
            ticks_q = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // everything is sampled mid-cycle, where the beat of the next edge is already settled
    always @(negedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            phase_q     = HUNT_LOW;
            ticks_q     = '0;
            bytes_q     = 0;
            break_min_q = BREAK_MIN_RST;
            timeout_q   = BYTE_TMO_RST;
            mismatches  = 0;
            pending_answers.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_BREAK_MIN)
                    break_min_q = pwdata[CNT_W-1:0];
                else
                    timeout_q = pwdata[CNT_W-1:0];
            end
            if (result_valid && !result_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("result beat with no item beat waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    check_field("frame_done", 16'(want.frame_done),
                                16'(result_data.frame_done));
                    check_field("frame_error", 16'(want.frame_error),
                                16'(result_data.frame_error));
                    check_field("channel_count", 16'(want.channel_count),
                                16'(result_data.channel_count));
                    check_field("read_valid", 16'(want.read_valid),
                                16'(result_data.read_valid));
                    check_field("read_data", 16'(want.read_data),
                                16'(result_data.read_data));
                end
            end
            if (item_valid && !item_stall)
                pending_answers.push_back(predict_answer(item_data));
        end
        waiting_results = pending_answers.size();
    end

endmodule

// File: dv/dmx512_frame_receiver_test.sv
// testbench top for the dmx512 frame receiver: stimulus, idling, watchdog and verdict
module dmx512_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dmx_pkg::*;

    // cycles without any beat before the run is declared hung
    localparam int STALL_LIMIT = 3000;
    // length of the long receiver hold-off that fills the block
    localparam int HOLD_OFF    = 300;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_t                 item_data    = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result_data;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // beats of the coming edge, taken mid-cycle so that nothing races the edge
    logic item_go   = 1'b0;
    logic result_go = 1'b0;
    logic cfg_go    = 1'b0;

    int mismatches;
    int waiting_results;

    // calm: neither side idles; hold_req: asks the receiver for one long hold-off
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    int items_sent  = 0;
    int reads_sent  = 0;
    int frames_sent = 0;
    int settings    = 1;

    // stimulus-side copy of the register values
    int cfg_bmin = int'(BREAK_MIN_RST);
    int cfg_tmo  = int'(BYTE_TMO_RST);

    // rough line tracker, only there so that reads go to slots that hold a byte
    int trk_low   = 0;
    int trk_quiet = 0;
    int trk_bytes = 0;
    bit trk_armed = 1'b0;
    bit trk_cap   = 1'b0;
    bit slot_seen [0:MAX_BYTES_DEF-1];
    int seen_slots [$];

    dmx512_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    dmx512_frame_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item_data       (item_data),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_data     (result_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .waiting_results (waiting_results)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
    begin
        item_go   <= rst_n && item_valid && !item_stall;
        result_go <= rst_n && result_valid && !result_stall;
        cfg_go    <= rst_n && psel && penable && pready;
    end

    // receiver: random stalls, none while calm, and one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_OFF)
                begin
                    result_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            result_stall <= !calm && ($urandom_range(99) < 24);
        end
    end

    // watchdog: any beat on either channel or the register port counts as progress
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (item_go || result_go || cfg_go)
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // offers one item beat, after a random idle gap, and waits for it to be taken
    task automatic push_item(input item_t it);
        while (!calm && $urandom_range(99) < 24)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        @(posedge clk);
        while (!item_go)
            @(posedge clk);
        items_sent++;
    endtask

    // line tick; the tracker follows the receiver's hunt and capture as it goes
    task automatic push_tick(input logic level, input logic bvalid, input logic [7:0] bval);
        item_t it;
        it.func          = FUNC_TICK;
        it.line_level    = level;
        it.byte_valid    = bvalid;
        it.byte_value    = bval;
        it.channel_index = CH_W'($urandom_range(1023));
        if (trk_cap)
        begin
            if (bvalid)
            begin
                if (!slot_seen[trk_bytes])
                begin
                    slot_seen[trk_bytes] = 1'b1;
                    seen_slots.push_back(trk_bytes);
                end
                trk_bytes++;
                trk_quiet = 0;
                if (trk_bytes >= MAX_BYTES_DEF)
                    trk_cap = 1'b0;
            end
            else
            begin
                if (trk_quiet < 65535)
                    trk_quiet++;
                if (trk_quiet >= cfg_tmo)
                    trk_cap = 1'b0;
            end
        end
        else if (trk_armed)
        begin
            // line back high after the break opens the capture
            if (level)
            begin
                trk_armed = 1'b0;
                trk_cap   = 1'b1;
                trk_quiet = 0;
                trk_bytes = 0;
            end
        end
        else if (level)
            trk_low = 0;
        else
        begin
            if (trk_low < 65535)
                trk_low++;
            if (trk_low >= cfg_bmin)
            begin
                trk_armed = 1'b1;
                trk_low   = 0;
            end
        end
        push_item(it);
    endtask

    task automatic push_read(input logic [CH_W-1:0] idx);
        item_t it;
        it.func          = FUNC_READ;
        it.line_level    = 1'($urandom_range(1));
        it.byte_valid    = 1'($urandom_range(1));
        it.byte_value    = 8'($urandom_range(255));
        it.channel_index = idx;
        reads_sent++;
        push_item(it);
    endtask

    // mostly slots known to hold a byte, now and then a slot past the end of the store
    task automatic push_random_read();
        if (seen_slots.size() > 0 && $urandom_range(9) != 0)
            push_read(CH_W'(seen_slots[$urandom_range(seen_slots.size() - 1)]));
        else
            push_read(CH_W'($urandom_range(1023, MAX_BYTES_DEF)));
    endtask

    // line ticks at random level with random bytes
    task automatic push_noise();
        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    // one frame on the line: maybe a low too short for a break, then the break,
    // the return to high, the bytes with gaps below the timeout, and the timeout
    task automatic send_frame(input int nbytes, input bit bad_start);
        int         gap_cap;
        int         i;
        logic [7:0] lead;
        // leave any capture or half-counted low from earlier noise behind first
        while (trk_cap || trk_armed || trk_low != 0)
            push_tick(1'b1, 1'b0, 8'($urandom_range(255)));
        if (cfg_bmin > 1 && $urandom_range(2) == 0)
        begin
            repeat ($urandom_range(1, (cfg_bmin > 9) ? 8 : cfg_bmin - 1))
                push_tick(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
            push_tick(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
        end
        // bytes during the break and on the rising tick must be dropped
        repeat (cfg_bmin + $urandom_range(2))
            push_tick(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
        push_tick(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
        gap_cap = (cfg_tmo > 16) ? 16 : cfg_tmo - 1;
        for (i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(gap_cap))
                    push_tick(1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)));
            if (i == 0)
                lead = bad_start ? 8'($urandom_range(1, 255)) : START_CODE;
            else
                lead = 8'($urandom_range(255));
            // line level is ignored during capture
            push_tick(1'($urandom_range(1)), 1'b1, lead);
            if ($urandom_range(9) == 0)
                push_random_read();
        end
        if (nbytes < MAX_BYTES_DEF)
            repeat (cfg_tmo)
                push_tick(1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)));
        frames_sent++;
    endtask

    // stop offering and wait until every answer is back, plus a little slack
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (waiting_results != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // setup then access phase; psel stays up so a second write can follow at once
    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!cfg_go)
            @(posedge clk);
    endtask

    task automatic set_config(input int bmin, input int tmo);
        reg_write({REG_BREAK_MIN, 2'b00}, bmin);
        reg_write({REG_BYTE_TMO, 2'b00}, tmo);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_bmin = bmin;
        cfg_tmo  = tmo;
        settings++;
    endtask

    initial
    begin
        int ph;
        int goal;
        int roll;
        int i;
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full frame at the reset values: an 88-tick break, closed by the byte count
        calm = 1'b1;
        repeat (cfg_bmin)
            push_tick(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
        push_tick(1'b1, 1'b1, 8'h44);        // return to high, byte dropped
        for (i = 0; i < MAX_BYTES_DEF; i++)
        begin
            push_tick(1'($urandom_range(1)), 1'b1,
                      (i == 0) ? START_CODE : 8'($urandom_range(255)));
            if ($urandom_range(15) == 0)
                push_random_read();
        end
        frames_sent++;
        push_tick(1'b1, 1'b1, 8'hC3);        // bytes after the full frame are dropped
        push_tick(1'b1, 1'b1, 8'h3C);
        push_read(CH_W'(MAX_BYTES_DEF - 1));
        push_read(10'd0);

        // directed part with a two-tick break and a three-tick timeout
        drain();
        set_config(2, 3);
        push_read(10'd1023);                 // past the end of the store
        push_read(CH_W'(MAX_BYTES_DEF));
        push_tick(1'b1, 1'b1, 8'h5A);        // byte while hunting is dropped
        push_tick(1'b0, 1'b1, 8'h11);        // single low, too short for a break
        push_tick(1'b1, 1'b0, 8'h00);
        push_tick(1'b0, 1'b0, 8'h00);
        push_tick(1'b0, 1'b1, 8'h22);        // break accepted here, byte dropped
        push_tick(1'b0, 1'b1, 8'h33);        // still low after the break
        push_tick(1'b1, 1'b1, 8'h44);        // return to high, byte dropped
        push_tick(1'b1, 1'b1, START_CODE);
        push_tick(1'b0, 1'b1, 8'hFF);        // low line ignored during capture
        push_read(10'd1);                    // read while capture is running
        push_tick(1'b0, 1'b0, 8'h00);
        push_tick(1'b1, 1'b1, 8'h01);
        repeat (3)
            push_tick(1'b1, 1'b0, 8'h00);    // timeout closes a two-channel frame
        push_read(10'd0);
        push_read(10'd2);
        send_frame(1, 1'b1);                 // nonzero start code
        send_frame(0, 1'b0);                 // no byte at all

        // random part: mostly well-formed frames, some line noise and reads
        for (ph = 0; ph < 4; ph++)
        begin
            drain();
            if (ph == 0)
                set_config(1, 1);            // lowest break and timeout
            else
                set_config($urandom_range(1, 6), $urandom_range(1, 16));
            goal = items_sent + 16;
            while (items_sent < goal)
            begin
                if (ph == 1 && !hold_done)
                begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                if (ph == 2 && !pause_done && goal - items_sent < 8)
                begin
                    drain();
                    pause_done = 1'b1;
                end
                roll = $urandom_range(9);
                if (roll < 6)
                    send_frame(($urandom_range(3) == 0) ? $urandom_range(9, 20)
                                                         : $urandom_range(8),
                               $urandom_range(4) == 0);
                else if (roll < 8)
                    repeat ($urandom_range(1, 6))
                        push_noise();
                else
                    push_random_read();
            end
            calm = 1'b0;
        end

        // longest break and timeout: a low far too short for a break
        while (trk_cap || trk_armed || trk_low != 0)
            push_tick(1'b1, 1'b0, 8'h00);
        drain();
        set_config(65535, 65535);
        repeat (10)
            push_tick(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
        push_tick(1'b1, 1'b1, 8'h00);
        push_random_read();

        item_valid <= 1'b0;
        @(posedge clk);
        while (waiting_results != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        $display("covered %0d item beats (%0d reads) in %0d frames over %0d register settings",
                 items_sent, reads_sent, frames_sent, settings);
        $display("full, short, empty and bad-start frames of up to %0d bytes, noise and a hold-off",
                 MAX_BYTES_DEF);
        if (mismatches == 0 && waiting_results == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
